### hw/rtl/cobs_crc8_packet_deframer_assert.svh
// Assertion macros for the COBS / CRC-8 packet deframer checker.
// Stand-alone: no dependencies beyond the file that includes it.
`ifndef COBS_CRC8_PACKET_DEFRAMER_ASSERT_SVH
`define COBS_CRC8_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCPD_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCPD_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### hw/rtl/ccpd_pkg.sv
// Shared constants and types of the COBS / CRC-8 packet deframer.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package ccpd_pkg;

    localparam int RX_FRAME_DEPTH = 64;
    localparam int MAX_PACKET     = 35;
    localparam int RUN_LIMIT      = 32;
    localparam int MIN_FRAME      = 4;
    localparam int MIN_PACKET     = 3;

    localparam int FCOUNT_W = $clog2(RX_FRAME_DEPTH + 1);
    localparam int FADDR_W  = $clog2(RX_FRAME_DEPTH);
    localparam int PCOUNT_W = $clog2(MAX_PACKET + 1);
    localparam int PADDR_W  = $clog2(MAX_PACKET);

    localparam int STATUS_W = 2;
    localparam int LEN_W    = 6;
    localparam int POS_W    = 5;
    localparam int TOTAL_W  = 32;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [STATUS_W-1:0] ST_GOOD  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FRAME = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRC   = 2'd2;

    typedef struct packed {
        logic clr;
        logic step;
    } crc_ctl_t;

    typedef struct packed {
        logic frame_err;
        logic crc_err;
        logic good;
    } bump_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          packet_type;
        logic [LEN_W-1:0]    payload_length;
        logic [7:0]          payload_byte;
        logic [POS_W-1:0]    byte_position;
        logic                byte_valid;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/ccpd_rx_if.sv
// Receive byte channel: valid/ready handshake carrying one link byte.
// Depends on ccpd_pkg.
`default_nettype none

interface ccpd_rx_if import ccpd_pkg::*; ();

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

### hw/rtl/ccpd_res_if.sv
// Result channel: valid/ready handshake carrying one deframer result.
// Depends on ccpd_pkg for field widths.
`default_nettype none

interface ccpd_res_if import ccpd_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [7:0]          packet_type;
    logic [LEN_W-1:0]    payload_length;
    logic [7:0]          payload_byte;
    logic [POS_W-1:0]    byte_position;
    logic                byte_valid;
    logic                last;
    logic [TOTAL_W-1:0]  framing_error_total;
    logic [TOTAL_W-1:0]  crc_error_total;
    logic [TOTAL_W-1:0]  packet_total;

    modport source (
        output valid, output status, output packet_type, output payload_length,
        output payload_byte, output byte_position, output byte_valid, output last,
        output framing_error_total, output crc_error_total, output packet_total,
        input ready
    );
    modport sink (
        input valid, input status, input packet_type, input payload_length,
        input payload_byte, input byte_position, input byte_valid, input last,
        input framing_error_total, input crc_error_total, input packet_total,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/ccpd_crc8.sv
// Shared CRC-8 unit (polynomial 0x07, MSB first), one byte per step.
// Depends on ccpd_pkg.
`default_nettype none

module ccpd_crc8 import ccpd_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire crc_ctl_t   ctl,
    input  wire logic [7:0] data,
    output logic [7:0]      crc
);

    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
        logic [7:0] c;
        c = c_in ^ d;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.clr)
        begin
            crc_next = 8'h00;
        end
        else if (ctl.step)
        begin
            crc_next = crc8_byte(crc_reg, data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= 8'h00;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire

### hw/rtl/ccpd_stats.sv
// Wrapping 32-bit counters of framing errors, CRC errors and good packets.
// Depends on ccpd_pkg.
`default_nettype none

module ccpd_stats import ccpd_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bump_t        bump,
    output logic [TOTAL_W-1:0] framing_error_total,
    output logic [TOTAL_W-1:0] crc_error_total,
    output logic [TOTAL_W-1:0] packet_total
);

    logic [TOTAL_W-1:0] frame_cnt_reg, frame_cnt_next;
    logic [TOTAL_W-1:0] crc_cnt_reg, crc_cnt_next;
    logic [TOTAL_W-1:0] good_cnt_reg, good_cnt_next;

    always_comb
    begin
        frame_cnt_next = frame_cnt_reg + TOTAL_W'(bump.frame_err);
        crc_cnt_next   = crc_cnt_reg + TOTAL_W'(bump.crc_err);
        good_cnt_next  = good_cnt_reg + TOTAL_W'(bump.good);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= '0;
            crc_cnt_reg   <= '0;
            good_cnt_reg  <= '0;
        end
        else
        begin
            frame_cnt_reg <= frame_cnt_next;
            crc_cnt_reg   <= crc_cnt_next;
            good_cnt_reg  <= good_cnt_next;
        end
    end

    assign framing_error_total = frame_cnt_reg;
    assign crc_error_total     = crc_cnt_reg;
    assign packet_total        = good_cnt_reg;

endmodule

`default_nettype wire

### hw/rtl/cobs_crc8_packet_deframer.sv
// COBS / CRC-8 packet deframer: sequencer, frame store and packet store.
// Depends on ccpd_pkg, ccpd_rx_if, ccpd_res_if, ccpd_crc8 and ccpd_stats.
//
// Use: link bytes enter on rx, one transaction per byte; results leave on
// result. A non-zero byte is written to the frame store and rx stays ready,
// unless the store is full, which drops the frame as a framing error.
// A zero byte closes the frame: a frame of MIN_FRAME bytes or more is walked
// by the sequencer, a fetch and a decode state per stored byte (one read port
// with a registered read), writing the decoded packet to the packet store and
// stepping the shared CRC-8 unit once per decoded byte, then checked in its
// own state; a shorter frame is a framing error. A good packet then gives one
// result per payload byte, each via a packet store read, a load and a present
// step, held by any stall; a packet with no payload or an error gives a single
// result. A delimiter with an empty store gives nothing. rx is not ready from
// the delimiter until the frame's last result has been taken; a stalled
// receiver holds the result and the whole block. Reset clears the byte count,
// the counters and the sequencer; the stores are not cleared, and no clearing
// pass runs, so rx is ready straight away.
`default_nettype none

module cobs_crc8_packet_deframer import ccpd_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ccpd_rx_if.sink     rx,
    ccpd_res_if.source  result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_DEC    = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_EFETCH = 3'd4;
    localparam logic [2:0] S_ELOAD  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam res_t RES_FRAME = '{
        status: ST_FRAME, packet_type: 8'h00, payload_length: '0,
        payload_byte: 8'h00, byte_position: '0, byte_valid: 1'b0, last: 1'b1
    };
    localparam res_t RES_CRC = '{
        status: ST_CRC, packet_type: 8'h00, payload_length: '0,
        payload_byte: 8'h00, byte_position: '0, byte_valid: 1'b0, last: 1'b1
    };

    logic [2:0]          state_reg, state_next;
    logic [FCOUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [FCOUNT_W-1:0] frame_len_reg, frame_len_next;
    logic [FCOUNT_W-1:0] rd_reg, rd_next;
    logic [PCOUNT_W-1:0] wr_reg, wr_next;
    logic [7:0]          left_reg, left_next;
    logic                pend_zero_reg, pend_zero_next;
    logic                fault_reg, fault_next;
    logic [7:0]          type_reg, type_next;
    logic [7:0]          plen_reg, plen_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    res_t                res_reg, res_next;

    logic [7:0]          fmem [RX_FRAME_DEPTH];
    logic [7:0]          fdata_reg;
    logic                fmem_we;

    logic [7:0]          pmem [MAX_PACKET];
    logic [7:0]          pdata_reg;
    logic                pmem_we;
    logic                wr_req;
    logic [7:0]          pmem_wdata;
    logic [PADDR_W-1:0]  pmem_raddr;

    crc_ctl_t            crc_ctl;
    logic [7:0]          crc_value;
    bump_t               bump;

    ccpd_crc8 u_crc8 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (pmem_wdata),
        .crc   (crc_value)
    );

    ccpd_stats u_stats (
        .clk                 (clk),
        .rst_n               (rst_n),
        .bump                (bump),
        .framing_error_total (result.framing_error_total),
        .crc_error_total     (result.crc_error_total),
        .packet_total        (result.packet_total)
    );

    // Payload bytes follow the type and length bytes.
    assign pmem_raddr = PADDR_W'(pos_reg) + PADDR_W'(2);

    always_comb
    begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        frame_len_next  = frame_len_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        left_next       = left_reg;
        pend_zero_next  = pend_zero_reg;
        fault_next      = fault_reg;
        type_next       = type_reg;
        plen_next       = plen_reg;
        pos_next        = pos_reg;
        res_next        = res_reg;
        fmem_we         = 1'b0;
        pmem_we         = 1'b0;
        wr_req          = 1'b0;
        pmem_wdata      = 8'h00;
        crc_ctl         = '0;
        bump            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (rx.valid)
                begin
                    if (rx.rx_byte != 8'h00)
                    begin
                        if (byte_count_reg < FCOUNT_W'(RX_FRAME_DEPTH))
                        begin
                            fmem_we         = 1'b1;
                            byte_count_next = byte_count_reg + FCOUNT_W'(1);
                        end
                        else
                        begin
                            // Store full: drop the byte and the frame.
                            byte_count_next = '0;
                            bump.frame_err  = 1'b1;
                            res_next        = RES_FRAME;
                            state_next      = S_OUT;
                        end
                    end
                    else if (byte_count_reg != '0)
                    begin
                        byte_count_next = '0;
                        if (byte_count_reg < FCOUNT_W'(MIN_FRAME))
                        begin
                            bump.frame_err = 1'b1;
                            res_next       = RES_FRAME;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            frame_len_next = byte_count_reg;
                            rd_next        = '0;
                            wr_next        = '0;
                            left_next      = 8'h00;
                            pend_zero_next = 1'b0;
                            fault_next     = 1'b0;
                            crc_ctl.clr    = 1'b1;
                            state_next     = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                state_next = S_DEC;
            end

            S_DEC:
            begin
                if (left_reg == 8'h00)
                begin
                    // Code byte: emit the zero owed by the previous short block.
                    left_next      = fdata_reg - 8'd1;
                    pend_zero_next = (fdata_reg != 8'hFF);
                    wr_req         = pend_zero_reg;
                    pmem_wdata     = 8'h00;
                end
                else
                begin
                    left_next  = left_reg - 8'd1;
                    wr_req     = 1'b1;
                    pmem_wdata = fdata_reg;
                end

                if (wr_req)
                begin
                    if (wr_reg == PCOUNT_W'(MAX_PACKET))
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        pmem_we      = 1'b1;
                        crc_ctl.step = 1'b1;
                        wr_next      = wr_reg + PCOUNT_W'(1);
                        if (wr_reg == PCOUNT_W'(0))
                        begin
                            type_next = pmem_wdata;
                        end
                        if (wr_reg == PCOUNT_W'(1))
                        begin
                            plen_next = pmem_wdata;
                        end
                    end
                end

                rd_next = rd_reg + FCOUNT_W'(1);
                if (fault_next || (rd_next == frame_len_reg))
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end

            S_CHECK:
            begin
                pos_next   = '0;
                state_next = S_OUT;
                // A block still open at the frame end ran past the frame.
                if (fault_reg || (left_reg != 8'h00) || (wr_reg < PCOUNT_W'(MIN_PACKET)))
                begin
                    bump.frame_err = 1'b1;
                    res_next       = RES_FRAME;
                end
                else if ((plen_reg > 8'(RUN_LIMIT))
                         || ((10'(plen_reg) + 10'd3) != 10'(wr_reg)))
                begin
                    bump.crc_err = 1'b1;
                    res_next     = RES_CRC;
                end
                else if (crc_value != 8'h00)
                begin
                    // CRC over the whole packet, check byte included, leaves zero.
                    bump.crc_err = 1'b1;
                    res_next     = RES_CRC;
                end
                else
                begin
                    bump.good = 1'b1;
                    if (plen_reg == 8'h00)
                    begin
                        res_next = '{
                            status: ST_GOOD, packet_type: type_reg, payload_length: '0,
                            payload_byte: 8'h00, byte_position: '0,
                            byte_valid: 1'b0, last: 1'b1
                        };
                    end
                    else
                    begin
                        state_next = S_EFETCH;
                    end
                end
            end

            S_EFETCH:
            begin
                state_next = S_ELOAD;
            end

            S_ELOAD:
            begin
                res_next = '{
                    status: ST_GOOD, packet_type: type_reg,
                    payload_length: plen_reg[LEN_W-1:0], payload_byte: pdata_reg,
                    byte_position: pos_reg, byte_valid: 1'b1,
                    last: ((8'(pos_reg) + 8'd1) == plen_reg)
                };
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (result.ready)
                begin
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + POS_W'(1);
                        state_next = S_EFETCH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            byte_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_len_reg <= frame_len_next;
        rd_reg        <= rd_next;
        wr_reg        <= wr_next;
        left_reg      <= left_next;
        pend_zero_reg <= pend_zero_next;
        fault_reg     <= fault_next;
        type_reg      <= type_next;
        plen_reg      <= plen_next;
        pos_reg       <= pos_next;
        res_reg       <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (fmem_we)
        begin
            fmem[byte_count_reg[FADDR_W-1:0]] <= rx.rx_byte;
        end
        fdata_reg <= fmem[rd_reg[FADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            pmem[wr_reg[PADDR_W-1:0]] <= pmem_wdata;
        end
        pdata_reg <= pmem[pmem_raddr];
    end

    assign rx.ready              = (state_reg == S_IDLE);
    assign result.valid          = (state_reg == S_OUT);
    assign result.status         = res_reg.status;
    assign result.packet_type    = res_reg.packet_type;
    assign result.payload_length = res_reg.payload_length;
    assign result.payload_byte   = res_reg.payload_byte;
    assign result.byte_position  = res_reg.byte_position;
    assign result.byte_valid     = res_reg.byte_valid;
    assign result.last           = res_reg.last;

endmodule

`default_nettype wire

### hw/rtl/ccpd_checker.sv
// Port-level checker for the COBS / CRC-8 packet deframer, bound to the top.
// Depends on ccpd_pkg and cobs_crc8_packet_deframer_assert.svh.
`default_nettype none

`include "cobs_crc8_packet_deframer_assert.svh"

module ccpd_checker import ccpd_pkg::*; (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rx_valid,
    input wire logic                rx_ready,
    input wire logic [7:0]          rx_byte,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire logic [STATUS_W-1:0] res_status,
    input wire logic                res_last
);

    // A pending result is held until taken.
    `CCPD_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)

    // No byte is taken while a result waits.
    `CCPD_ASSERT_IMP(a_no_rx_while_res, clk, rst_n, res_valid, !rx_ready)

    // More results of the run follow, so rx stays closed.
    `CCPD_ASSERT_NXT(a_run_blocks_rx, clk, rst_n, res_valid && res_ready && !res_last,
        !rx_ready)

    // A data byte only ever causes an overflow result.
    `CCPD_ASSERT_NXT(a_data_byte_result, clk, rst_n,
        rx_valid && rx_ready && (rx_byte != 8'h00),
        !res_valid || (res_status == ST_FRAME))

endmodule

bind cobs_crc8_packet_deframer ccpd_checker u_ccpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx.valid),
    .rx_ready   (rx.ready),
    .rx_byte    (rx.rx_byte),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_last   (result.last)
);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the COBS / CRC-8 packet deframer: self-checking, with a scoreboard class.
// Depends on ccpd_pkg, ccpd_rx_if, ccpd_res_if and cobs_crc8_packet_deframer.

module tb_top;
    import ccpd_pkg::*;

    typedef logic [7:0] octet_q_t [$];

    typedef struct {
        res_t        fields;
        logic [31:0] framing_total;
        logic [31:0] crc_total;
        logic [31:0] packet_total;
    } awaited_result_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_LENGTH,
        FAULT_OVERSIZE_LEN
    } packet_fault_t;

    localparam int RANDOM_ITEMS = 170;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 50;
    localparam int LONG_HOLD    = 300;
    localparam int PRINT_LIMIT  = 20;

    class deframer_scoreboard_t;
        logic [7:0]      frame_bytes [RX_FRAME_DEPTH];
        int unsigned     frame_len;
        logic [7:0]      decoded [MAX_PACKET];
        logic [31:0]     framing_tally;
        logic [31:0]     crc_tally;
        logic [31:0]     good_packets;
        awaited_result_t awaited_results [$];
        int unsigned     mismatches;
        int unsigned     results_checked;

        function new();
            frame_len       = 0;
            framing_tally   = '0;
            crc_tally       = '0;
            good_packets    = '0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        static function logic [7:0] crc8_07(octet_q_t data);
            logic [7:0] c;
            c = 8'h00;
            foreach (data[i])
            begin
                c = c ^ data[i];
                repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            return c;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void push_result(logic [1:0] status, logic [7:0] ptype, logic [5:0] plen,
                                  logic [7:0] pbyte, logic [4:0] pos, logic pvalid,
                                  logic plast);
            awaited_result_t r;
            r.fields.status         = status;
            r.fields.packet_type    = ptype;
            r.fields.payload_length = plen;
            r.fields.payload_byte   = pbyte;
            r.fields.byte_position  = pos;
            r.fields.byte_valid     = pvalid;
            r.fields.last           = plast;
            r.framing_total         = framing_tally;
            r.crc_total             = crc_tally;
            r.packet_total          = good_packets;
            awaited_results.push_back(r);
        endfunction

        function void flag_framing();
            framing_tally++;
            push_result(ST_FRAME, '0, '0, '0, '0, 1'b0, 1'b1);
        endfunction

        function void flag_crc();
            crc_tally++;
            push_result(ST_CRC, '0, '0, '0, '0, 1'b0, 1'b1);
        endfunction

        // Unstuff the frame into the packet buffer; -1 on any COBS fault.
        function int unstuff_frame();
            int rd;
            int wr;
            int code;
            rd = 0;
            wr = 0;
            while (rd < int'(frame_len))
            begin
                code = int'(frame_bytes[rd]);
                rd++;
                if (code == 0)
                    return -1;
                for (int k = 1; k < code; k++)
                begin
                    if (rd >= int'(frame_len) || wr >= MAX_PACKET)
                        return -1;
                    decoded[wr] = frame_bytes[rd];
                    wr++;
                    rd++;
                end
                if (code < 255 && rd < int'(frame_len))
                begin
                    if (wr >= MAX_PACKET)
                        return -1;
                    decoded[wr] = 8'h00;
                    wr++;
                end
            end
            return wr;
        endfunction

        function void close_frame();
            int         dec;
            int         plen;
            logic [7:0] ptype;
            octet_q_t   covered;
            if (frame_len < MIN_FRAME)
            begin
                flag_framing();
                return;
            end
            dec = unstuff_frame();
            if (dec < MIN_PACKET)
            begin
                flag_framing();
                return;
            end
            ptype = decoded[0];
            plen  = int'(decoded[1]);
            if (plen > RUN_LIMIT || dec != plen + 3)
            begin
                flag_crc();
                return;
            end
            for (int i = 0; i < plen + 2; i++)
                covered.push_back(decoded[i]);
            if (crc8_07(covered) != decoded[plen + 2])
            begin
                flag_crc();
                return;
            end
            good_packets++;
            if (plen == 0)
                push_result(ST_GOOD, ptype, '0, '0, '0, 1'b0, 1'b1);
            else
                for (int i = 0; i < plen; i++)
                    push_result(ST_GOOD, ptype, 6'(plen), decoded[2 + i], 5'(i), 1'b1,
                                (i == plen - 1));
        endfunction

        // Note one accepted link byte and queue the results it causes.
        function void absorb_link_byte(logic [7:0] b);
            if (b == 8'h00)
            begin
                if (frame_len > 0)
                    close_frame();
                frame_len = 0;
            end
            else if (frame_len < RX_FRAME_DEPTH)
            begin
                frame_bytes[frame_len] = b;
                frame_len++;
            end
            else
            begin
                frame_len = 0;
                flag_framing();
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %0h, expected %0h",
                                          results_checked, name, got, want));
        endtask

        task check_result(res_t got, logic [31:0] fe, logic [31:0] ce, logic [31:0] pk);
            awaited_result_t want;
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with none awaited, status %0d",
                                          results_checked, got.status));
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", 32'(got.status), 32'(want.fields.status));
            compare_field("packet_type", 32'(got.packet_type),
                          32'(want.fields.packet_type));
            compare_field("payload_length", 32'(got.payload_length),
                          32'(want.fields.payload_length));
            compare_field("payload_byte", 32'(got.payload_byte),
                          32'(want.fields.payload_byte));
            compare_field("byte_position", 32'(got.byte_position),
                          32'(want.fields.byte_position));
            compare_field("byte_valid", 32'(got.byte_valid), 32'(want.fields.byte_valid));
            compare_field("last", 32'(got.last), 32'(want.fields.last));
            compare_field("framing_error_total", fe, want.framing_total);
            compare_field("crc_error_total", ce, want.crc_total);
            compare_field("packet_total", pk, want.packet_total);
        endtask
    endclass

    logic clk;
    logic rst_n;

    ccpd_rx_if  rx_ch ();
    ccpd_res_if res_ch ();

    cobs_crc8_packet_deframer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    deframer_scoreboard_t sb;
    bit          idle_off;
    int          receiver_hold_cycles;
    int unsigned cycle_count;
    int unsigned bytes_counted;
    int unsigned frames_sent;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready = 1'b0;
        idle_off = 1'b0;
        receiver_hold_cycles = 0;
        cycle_count = 0;
        bytes_counted = 0;
        frames_sent = 0;
        sb = new();
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stalls per result, plus one long hold when asked for.
    initial
    begin : result_sink
        int   gap;
        res_t got;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = idle_off ? 0 : $urandom_range(0, 7);
            if (receiver_hold_cycles > 0)
            begin
                gap = receiver_hold_cycles;
                receiver_hold_cycles = 0;
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got.status         = res_ch.status;
            got.packet_type    = res_ch.packet_type;
            got.payload_length = res_ch.payload_length;
            got.payload_byte   = res_ch.payload_byte;
            got.byte_position  = res_ch.byte_position;
            got.byte_valid     = res_ch.byte_valid;
            got.last           = res_ch.last;
            sb.check_result(got, res_ch.framing_error_total, res_ch.crc_error_total,
                            res_ch.packet_total);
        end
    end

    // Called at a rising edge; returns at the edge where the transaction completes.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        // a delimiter on an empty store does nothing, so leave it out of the tally
        if (b != 8'h00 || sb.frame_len != 0)
            bytes_counted++;
        sb.absorb_link_byte(b);
    endtask

    task automatic send_frame(input octet_q_t frame);
        foreach (frame[i])
            send_byte(frame[i]);
        send_byte(8'h00);
        frames_sent++;
    endtask

    // Build type, length, payload and CRC, then COBS-stuff it. Packets stay well
    // under 254 bytes, so no full-length block is ever needed.
    function automatic octet_q_t encode_packet(logic [7:0] ptype, octet_q_t payload,
                                               packet_fault_t fault);
        octet_q_t   raw;
        octet_q_t   enc;
        logic [7:0] len_field;
        logic [7:0] crc;
        logic [7:0] code;
        int         code_at;
        len_field = 8'(payload.size());
        if (fault == FAULT_LENGTH)
            len_field = len_field + 8'd1;
        if (fault == FAULT_OVERSIZE_LEN)
            len_field = 8'($urandom_range(RUN_LIMIT + 1, 255));
        raw = {ptype, len_field};
        foreach (payload[i])
            raw.push_back(payload[i]);
        crc = deframer_scoreboard_t::crc8_07(raw);
        if (fault == FAULT_CRC)
            crc = crc ^ 8'($urandom_range(1, 255));
        raw.push_back(crc);
        enc = {8'h00};
        code_at = 0;
        code = 8'd1;
        foreach (raw[i])
        begin
            if (raw[i] == 8'h00)
            begin
                enc[code_at] = code;
                code_at = enc.size();
                enc.push_back(8'h00);
                code = 8'd1;
            end
            else
            begin
                enc.push_back(raw[i]);
                code++;
            end
        end
        enc[code_at] = code;
        return enc;
    endfunction

    task automatic send_random_packet(input bit force_good);
        octet_q_t      payload;
        int            plen;
        int            pick;
        packet_fault_t fault;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, RUN_LIMIT) : $urandom_range(0, 8);
        for (int i = 0; i < plen; i++)
            payload.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        pick = force_good ? 0 : $urandom_range(0, 19);
        if (pick < 15)
            fault = FAULT_NONE;
        else if (pick < 17)
            fault = FAULT_CRC;
        else if (pick < 19)
            fault = FAULT_LENGTH;
        else
            fault = FAULT_OVERSIZE_LEN;
        send_frame(encode_packet(8'($urandom), payload, fault));
    endtask

    task automatic send_noise(input int count, input bit nonzero);
        for (int i = 0; i < count; i++)
            send_byte(nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        octet_q_t    payload;
        octet_q_t    frame;
        int unsigned random_start;
        int          pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone delimiter, empty, full-size and single-zero-byte good packets.
        send_byte(8'h00);
        payload = {};
        send_frame(encode_packet(8'h00, payload, FAULT_NONE));
        for (int i = 0; i < RUN_LIMIT; i++)
            payload.push_back((i % 5 == 0) ? 8'h00 : ((i % 5 == 1) ? 8'hFF : 8'(i * 37)));
        send_frame(encode_packet(8'hFF, payload, FAULT_NONE));
        payload = {8'h00};
        send_frame(encode_packet(8'h5A, payload, FAULT_NONE));

        // Short frame, block running past the frame end, oversized decode, 0xFF block running past the end.
        frame = {8'h01, 8'h02, 8'h03};
        send_frame(frame);
        frame = {8'h05, 8'h11, 8'h22, 8'h33};
        send_frame(frame);
        frame = {};
        repeat (40) frame.push_back(8'h01);
        send_frame(frame);
        frame = {8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
        send_frame(frame);

        // Length mismatch, length above the run limit, bad CRC.
        payload = {8'h12, 8'h34};
        send_frame(encode_packet(8'h01, payload, FAULT_LENGTH));
        send_frame(encode_packet(8'h02, payload, FAULT_OVERSIZE_LEN));
        send_frame(encode_packet(8'h03, payload, FAULT_CRC));

        // Overflow the frame store; the delimiter after it finds an empty store.
        send_noise(RX_FRAME_DEPTH + 1, 1'b1);
        send_byte(8'h00);

        // Hold the sender until everything has drained.
        wait_drained();

        // Long receiver hold while the sender keeps offering frames.
        receiver_hold_cycles = LONG_HOLD;
        repeat (4) send_random_packet(1'b1);

        random_start = bytes_counted;
        while (bytes_counted - random_start < RANDOM_ITEMS)
        begin
            idle_off = (bytes_counted - random_start >= 60 &&
                        bytes_counted - random_start < 100);
            pick = $urandom_range(0, 49);
            if (pick < 45)
                send_random_packet(1'b0);
            else if (pick < 49)
            begin
                send_noise($urandom_range(1, 12), 1'b0);
                send_byte(8'h00);
            end
            else
            begin
                send_noise($urandom_range(RX_FRAME_DEPTH, RX_FRAME_DEPTH + 6), 1'b1);
                send_byte(8'h00);
            end
        end
        idle_off = 1'b0;
        rx_ch.valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d link bytes in %0d frames; checked %0d results.",
                 bytes_counted, frames_sent, sb.results_checked);
        $display("Predicted %0d good packets, %0d framing errors, %0d CRC errors.",
                 sb.good_packets, sb.framing_tally, sb.crc_tally);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
